// ===== design/u8vd_pkg.sv =====
// u8vd_pkg: shared types, constants and byte classification functions
// for the UTF-8 validating decoder. Depends on nothing.

package u8vd_pkg;

   localparam int MAX_SEQ_BYTES_DEF = 6;
   localparam int MAX_SEQ_BYTES_MIN = 4;
   localparam int MAX_SEQ_BYTES_MAX = 6;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 31;
   localparam int LEN_W  = 3;

   localparam logic [BYTE_W-1:0] CONT_MIN      = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MAX      = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_MIN     = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD3_MIN     = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN     = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_MIN     = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD6_MIN     = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD_ILL_MIN  = 8'hFE;
   localparam logic [BYTE_W-1:0] LEAD_SURR     = 8'hED;
   localparam logic [BYTE_W-1:0] SEC_MIN_E0    = 8'hA0;
   localparam logic [BYTE_W-1:0] SEC_MAX_ED    = 8'h9F;
   localparam logic [BYTE_W-1:0] SEC_MIN_F0    = 8'h90;
   localparam logic [BYTE_W-1:0] SEC_MIN_F8    = 8'h88;
   localparam logic [BYTE_W-1:0] SEC_MIN_FC    = 8'h84;
   localparam logic [5:0]        PAYLOAD_MASK  = 6'h3F;

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
   localparam logic [LEN_W-1:0] LEN_5    = 3'd5;
   localparam logic [LEN_W-1:0] LEN_6    = 3'd6;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ILLEGAL = 1'b1;

   typedef struct packed {
      logic             emit;
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             status;
   } result_type;

   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      if (b < CONT_MIN)
         len = LEN_1;
      else if (b < LEAD2_MIN)
         len = LEN_NONE;
      else if (b < LEAD3_MIN)
         len = LEN_2;
      else if (b < LEAD4_MIN)
         len = LEN_3;
      else if (b < LEAD5_MIN)
         len = LEN_4;
      else if (b < LEAD6_MIN)
         len = LEN_5;
      else if (b < LEAD_ILL_MIN)
         len = LEN_6;
      else
         len = LEN_NONE;
      return len;
   endfunction

   function automatic logic [BYTE_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
      logic [BYTE_W-1:0] m;
      case (len)
         LEN_2:   m = 8'h1F;
         LEN_3:   m = 8'h0F;
         LEN_4:   m = 8'h07;
         LEN_5:   m = 8'h03;
         LEN_6:   m = 8'h01;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic logic second_ok(input logic [BYTE_W-1:0] lead,
                                      input logic [BYTE_W-1:0] b);
      logic ok;
      case (lead)
         LEAD3_MIN: ok = (b >= SEC_MIN_E0);
         LEAD_SURR: ok = (b <= SEC_MAX_ED);
         LEAD4_MIN: ok = (b >= SEC_MIN_F0);
         LEAD5_MIN: ok = (b >= SEC_MIN_F8);
         LEAD6_MIN: ok = (b >= SEC_MIN_FC);
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

// ===== design/utf8_validating_decoder.sv =====
// utf8_validating_decoder: top level with input register, decode core and
// result register. Depends on u8vd_pkg and u8vd_core.
//
// Usage:
//   req channel: one raw byte per beat (req_in_byte) with req_buffer_end set
//   on the last byte available in the buffer. A beat is taken on a rising
//   edge with req_valid high and req_stall low.
//   rsp channel: at most one result per input byte: code_point, seq_length
//   and status (0 decoded, 1 illegal or truncated). Continuation bytes that
//   do not end a sequence give no result.
//   Path: a byte taken lands in the input register; its result is then
//   registered in the result register and shows on rsp_valid.
//   Throughput: one byte per clock while not stalled. The sequence state
//   is updated in the single decode step between the two registers.
//   Stall: a result waiting under rsp_stall holds; the input register keeps
//   moving for bytes that produce no result, holds for others only while a
//   stalled result waits, and req_stall rises only while it is blocked.
//   Reset: synchronous; empties both registers and returns the decoder to
//   idle with no partial sequence.

module utf8_validating_decoder #(
   parameter int MAX_SEQ_BYTES = u8vd_pkg::MAX_SEQ_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [u8vd_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                          req_buffer_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [u8vd_pkg::CP_W-1:0]     rsp_code_point,
   output logic [u8vd_pkg::LEN_W-1:0]    rsp_seq_length,
   output logic                          rsp_status
);

   logic                        in_valid_ff;
   logic [u8vd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_last_ff;

   logic                        out_valid_ff;
   logic [u8vd_pkg::CP_W-1:0]   out_cp_ff;
   logic [u8vd_pkg::LEN_W-1:0]  out_len_ff;
   logic                        out_status_ff;

   u8vd_pkg::result_type        step_result;
   logic                        advance;

   u8vd_core #(
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_byte   (in_byte_ff),
      .step_last   (in_last_ff),
      .step_result (step_result)
   );

   assign advance   = in_valid_ff && (!step_result.emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_result.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.emit) begin
         out_cp_ff     <= step_result.code_point;
         out_len_ff    <= step_result.seq_length;
         out_status_ff <= step_result.status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_seq_length = out_len_ff;
   assign rsp_status     = out_status_ff;

endmodule

// ===== design/u8vd_core.sv =====
// u8vd_core: sequence state and one-beat decode step of the UTF-8 decoder.
// Depends on u8vd_pkg.

module u8vd_core #(
   parameter int MAX_SEQ_BYTES = u8vd_pkg::MAX_SEQ_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_valid,
   input  logic [u8vd_pkg::BYTE_W-1:0]   step_byte,
   input  logic                          step_last,
   output u8vd_pkg::result_type          step_result
);

   localparam logic [u8vd_pkg::LEN_W-1:0] MAX_LEN = u8vd_pkg::LEN_W'(MAX_SEQ_BYTES);

   logic [u8vd_pkg::LEN_W-1:0]  left_ff,   left_in;
   logic [u8vd_pkg::LEN_W-1:0]  total_ff,  total_in;
   logic [u8vd_pkg::CP_W-1:0]   accum_ff,  accum_in;
   logic [u8vd_pkg::BYTE_W-1:0] lead_ff,   lead_in;
   logic                        second_ff, second_in;

   logic [u8vd_pkg::LEN_W-1:0]  lead_len;
   logic [u8vd_pkg::LEN_W-1:0]  left_dec;
   logic [u8vd_pkg::CP_W-1:0]   accum_shift;
   logic                        cont_bad;

   assign lead_len    = u8vd_pkg::lead_length(step_byte);
   assign left_dec    = left_ff - u8vd_pkg::LEN_1;
   assign accum_shift = {accum_ff[u8vd_pkg::CP_W-7:0], step_byte[5:0] & u8vd_pkg::PAYLOAD_MASK};
   assign cont_bad    = (step_byte < u8vd_pkg::CONT_MIN) || (step_byte > u8vd_pkg::CONT_MAX)
                        || (second_ff && !u8vd_pkg::second_ok(lead_ff, step_byte));

   always_comb begin
      step_result = '0;
      left_in     = '0;
      total_in    = '0;
      accum_in    = '0;
      lead_in     = '0;
      second_in   = 1'b0;
      if (left_ff == u8vd_pkg::LEN_NONE) begin
         if (lead_len == u8vd_pkg::LEN_NONE || lead_len > MAX_LEN) begin
            step_result.emit   = 1'b1;
            step_result.status = u8vd_pkg::STATUS_ILLEGAL;
         end else if (lead_len == u8vd_pkg::LEN_1) begin
            step_result.emit       = 1'b1;
            step_result.code_point = {{(u8vd_pkg::CP_W-u8vd_pkg::BYTE_W){1'b0}}, step_byte};
            step_result.seq_length = u8vd_pkg::LEN_1;
            step_result.status     = u8vd_pkg::STATUS_OK;
         end else if (step_last) begin
            step_result.emit   = 1'b1;
            step_result.status = u8vd_pkg::STATUS_ILLEGAL;
         end else begin
            left_in   = lead_len - u8vd_pkg::LEN_1;
            total_in  = lead_len;
            accum_in  = {{(u8vd_pkg::CP_W-u8vd_pkg::BYTE_W){1'b0}},
                         step_byte & u8vd_pkg::lead_mask(lead_len)};
            lead_in   = step_byte;
            second_in = 1'b1;
         end
      end else if (cont_bad) begin
         step_result.emit   = 1'b1;
         step_result.status = u8vd_pkg::STATUS_ILLEGAL;
      end else if (left_dec == u8vd_pkg::LEN_NONE) begin
         step_result.emit       = 1'b1;
         step_result.code_point = accum_shift;
         step_result.seq_length = total_ff;
         step_result.status     = u8vd_pkg::STATUS_OK;
      end else if (step_last) begin
         step_result.emit   = 1'b1;
         step_result.status = u8vd_pkg::STATUS_ILLEGAL;
      end else begin
         left_in   = left_dec;
         total_in  = total_ff;
         accum_in  = accum_shift;
         lead_in   = lead_ff;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         total_ff  <= '0;
         accum_ff  <= '0;
         lead_ff   <= '0;
         second_ff <= 1'b0;
      end else if (step_valid) begin
         left_ff   <= left_in;
         total_ff  <= total_in;
         accum_ff  <= accum_in;
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

endmodule

// ===== design/u8vd_checker.sv =====
// u8vd_checker: port-level checks on the UTF-8 decoder result channel,
// bound to the top level. Depends on u8vd_pkg and utf8_validating_decoder.

module u8vd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [u8vd_pkg::CP_W-1:0]     rsp_code_point,
   input logic [u8vd_pkg::LEN_W-1:0]    rsp_seq_length,
   input logic                          rsp_status
);

   a_rst_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_illegal_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8vd_pkg::STATUS_ILLEGAL
      |-> rsp_code_point == '0 && rsp_seq_length == u8vd_pkg::LEN_NONE)
      else $error("illegal result carries data");

   a_ok_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8vd_pkg::STATUS_OK
      |-> rsp_seq_length >= u8vd_pkg::LEN_1 && rsp_seq_length <= u8vd_pkg::LEN_6)
      else $error("decoded result with bad length");

   a_ascii : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8vd_pkg::STATUS_OK && rsp_seq_length == u8vd_pkg::LEN_1
      |-> rsp_code_point[u8vd_pkg::CP_W-1:7] == '0)
      else $error("single-byte result above 7 bits");

endmodule

bind utf8_validating_decoder u8vd_checker u_checker (.*);
